[rtl/signed_integer_to_radix_symbols_macros.svh]
// Assertion macros shared by the checker of the radix symbol renderer.
`ifndef SIGNED_INTEGER_TO_RADIX_SYMBOLS_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_SYMBOLS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sirs_pkg.sv]
// Types and constants shared by the radix symbol renderer.
package sirs_pkg;

   localparam int unsigned WORD_BITS     = 32;
   localparam int unsigned SYMBOL_BITS   = 8;
   localparam int unsigned MAX_DIGITS    = 32;
   localparam int unsigned ALPHABET_SIZE = 16;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [SYMBOL_BITS-1:0] PLUS_CHAR  = 8'h2B;
   localparam logic [SYMBOL_BITS-1:0] MINUS_CHAR = 8'h2D;

   localparam logic [1:0] CSR_RADIX        = 2'd0;
   localparam logic [1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [1:0] CSR_SYMBOLS_HIGH = 2'd2;

   // Reciprocals floor(2^32 / r), indexed by the low four bits of the radix.
   // A radix of 16 wraps to index zero; index one is never used.
   localparam logic [WORD_BITS-1:0] RECIP_TABLE [ALPHABET_SIZE] = '{
      32'd268435456,  32'd0,          32'd2147483648, 32'd1431655765,
      32'd1073741824, 32'd858993459,  32'd715827882,  32'd613566756,
      32'd536870912,  32'd477218588,  32'd429496729,  32'd390451572,
      32'd357913941,  32'd330382099,  32'd306783378,  32'd286331153
   };

   typedef struct packed {
      logic                 neg;
      logic [WORD_BITS-1:0] mag;
      logic                 bad;
   } sirs_word_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MUL,
      BACK_DIV,
      BACK_SIGN,
      BACK_EMIT,
      BACK_ERROR
   } sirs_back_state_type;

endpackage

[rtl/sirs_queue.sv]
// Short queue of classified words between the front and the back.
module sirs_queue import sirs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sirs_word_type push_word,
   output logic          full,
   input  logic          pop,
   output logic          pop_valid,
   output sirs_word_type pop_word
);

   localparam int unsigned PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   sirs_word_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_word  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[rtl/sirs_front.sv]
// Front end: accepts numbers, checks radix and alphabet, forms magnitude.
module sirs_front import sirs_pkg::*; #(
   parameter int unsigned MAX_RADIX = 16
) (
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [WORD_BITS-1:0]           req_number,
   input  logic [4:0]                            radix,
   input  logic [ALPHABET_SIZE*SYMBOL_BITS-1:0]  alphabet,
   input  logic                                  queue_full,
   output logic                                  push,
   output sirs_word_type                         push_word
);

   logic [WORD_BITS-1:0] raw;
   logic                 bad;

   assign raw       = req_number;
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      bad = (radix < 5'd2) || (radix > 5'(MAX_RADIX));
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         if (5'(i) < radix) begin
            if ((alphabet[i*SYMBOL_BITS +: SYMBOL_BITS] == PLUS_CHAR) ||
                (alphabet[i*SYMBOL_BITS +: SYMBOL_BITS] == MINUS_CHAR)) begin
               bad = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
               if (alphabet[j*SYMBOL_BITS +: SYMBOL_BITS] ==
                   alphabet[i*SYMBOL_BITS +: SYMBOL_BITS]) begin
                  bad = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      push_word.neg = raw[WORD_BITS-1];
      push_word.mag = raw[WORD_BITS-1] ? (~raw + 1'b1) : raw;
      push_word.bad = bad;
   end

endmodule

[rtl/sirs_back.sv]
// Back end: divides out the digits and sends the symbols, most significant first.
module sirs_back import sirs_pkg::*; #(
   parameter int unsigned MAX_RADIX = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_valid,
   input  sirs_word_type                        q_word,
   output logic                                 q_pop,
   input  logic [4:0]                           radix,
   input  logic [ALPHABET_SIZE*SYMBOL_BITS-1:0] alphabet,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [SYMBOL_BITS-1:0]               rsp_symbol,
   output logic                                 rsp_last,
   output logic                                 rsp_bad_base
);

   localparam int unsigned DIGIT_BITS = $clog2(MAX_RADIX);

   sirs_back_state_type    state_ff, state_in;
   logic [WORD_BITS-1:0]   mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [2*WORD_BITS-1:0] prod_ff, prod_in;
   logic [5:0]             count_ff, count_in;
   logic [DIGIT_BITS-1:0]  digits_ff [MAX_DIGITS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_BITS-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_bad_base_ff, rsp_bad_base_in;

   logic                   out_free;
   logic [WORD_BITS-1:0]   qhat, rem, quot;
   logic [WORD_BITS+4:0]   scaled;
   logic [DIGIT_BITS-1:0]  digit;
   logic                   digit_we;
   logic [5:0]             count_dec;
   logic [DIGIT_BITS-1:0]  read_digit;
   logic [3:0]             sym_index;
   logic [SYMBOL_BITS-1:0] digit_symbol;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_symbol   = rsp_symbol_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_bad_base = rsp_bad_base_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // The reciprocal estimate is low by at most one; a single correction fixes it.
   always_comb begin
      qhat   = prod_ff[2*WORD_BITS-1:WORD_BITS];
      scaled = (WORD_BITS+5)'(qhat) * (WORD_BITS+5)'(radix);
      rem    = mag_ff - scaled[WORD_BITS-1:0];
      if (rem >= WORD_BITS'(radix)) begin
         quot  = qhat + 1'b1;
         digit = DIGIT_BITS'(rem - WORD_BITS'(radix));
      end else begin
         quot  = qhat;
         digit = DIGIT_BITS'(rem);
      end
   end

   assign count_dec    = count_ff - 6'd1;
   assign read_digit   = digits_ff[count_dec[4:0]];
   assign sym_index    = 4'(read_digit);
   assign digit_symbol = alphabet[{sym_index, 3'b000} +: SYMBOL_BITS];

   always_comb begin
      state_in        = state_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      prod_in         = prod_ff;
      count_in        = count_ff;
      digit_we        = 1'b0;
      q_pop           = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_bad_base_in = rsp_bad_base_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               mag_in   = q_word.mag;
               neg_in   = q_word.neg;
               count_in = '0;
               state_in = q_word.bad ? BACK_ERROR : BACK_MUL;
            end
         end
         BACK_MUL: begin
            prod_in  = (2*WORD_BITS)'(mag_ff) * (2*WORD_BITS)'(RECIP_TABLE[radix[3:0]]);
            state_in = BACK_DIV;
         end
         BACK_DIV: begin
            digit_we = 1'b1;
            count_in = count_ff + 6'd1;
            mag_in   = quot;
            if ((quot == '0) || (count_ff == 6'(MAX_DIGITS - 1))) begin
               state_in = neg_ff ? BACK_SIGN : BACK_EMIT;
            end else begin
               state_in = BACK_MUL;
            end
         end
         BACK_SIGN: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_symbol_in   = MINUS_CHAR;
               rsp_last_in     = 1'b0;
               rsp_bad_base_in = 1'b0;
               state_in        = BACK_EMIT;
            end
         end
         BACK_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_symbol_in   = digit_symbol;
               rsp_last_in     = (count_ff == 6'd1);
               rsp_bad_base_in = 1'b0;
               count_in        = count_dec;
               if (count_ff == 6'd1) begin
                  state_in = BACK_IDLE;
               end
            end
         end
         BACK_ERROR: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_symbol_in   = '0;
               rsp_last_in     = 1'b1;
               rsp_bad_base_in = 1'b1;
               state_in        = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff          <= mag_in;
      neg_ff          <= neg_in;
      prod_ff         <= prod_in;
      count_ff        <= count_in;
      rsp_symbol_ff   <= rsp_symbol_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_bad_base_ff <= rsp_bad_base_in;
      if (digit_we) begin
         digits_ff[count_ff[4:0]] <= digit;
      end
   end

endmodule

[rtl/signed_integer_to_radix_symbols.sv]
// Top level of the signed integer to radix symbol renderer.
// A number arrives on the req_ channel as a signed 32-bit word. Its text in the
// configured base leaves on the rsp_ channel, one symbol per word, most
// significant digit first, with a leading minus sign for negative numbers and
// rsp_last set on the final word. If the radix or the alphabet is invalid, a
// single word with rsp_bad_base and rsp_last set and a zero symbol is sent
// instead. The csr_ port writes the radix and the two alphabet registers; the
// user must write it only while no number is in flight, as the block itself
// does not enforce this. A number with n digits leaves the queue, then passes
// the divide loop once per digit (a 32x32 reciprocal multiply, then a
// correction), then a sign state if negative, and then sends its symbols, each
// when the output is free. A two-entry queue lets new numbers be taken while
// one is rendered.
// A stalled rsp_ready holds the output word and then the back end; the front
// keeps accepting until the queue fills. Synchronous reset empties the queue,
// drops any output word and clears the configuration registers to zero.
module signed_integer_to_radix_symbols import sirs_pkg::*; #(
   parameter int unsigned MAX_RADIX = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [WORD_BITS-1:0]   req_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [SYMBOL_BITS-1:0]        rsp_symbol,
   output logic                          rsp_last,
   output logic                          rsp_bad_base,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [63:0]                   csr_write_data
);

   logic [4:0]    radix_ff, radix_in;
   logic [63:0]   symbols_low_ff, symbols_low_in;
   logic [63:0]   symbols_high_ff, symbols_high_in;
   logic [ALPHABET_SIZE*SYMBOL_BITS-1:0] alphabet;
   logic          push, queue_full, q_valid, q_pop;
   sirs_word_type push_word, q_word;

   assign alphabet = {symbols_high_ff, symbols_low_ff};

   always_comb begin
      radix_in        = radix_ff;
      symbols_low_in  = symbols_low_ff;
      symbols_high_in = symbols_high_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RADIX:        radix_in        = csr_write_data[4:0];
            CSR_SYMBOLS_LOW:  symbols_low_in  = csr_write_data;
            CSR_SYMBOLS_HIGH: symbols_high_in = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff        <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
      end else begin
         radix_ff        <= radix_in;
         symbols_low_ff  <= symbols_low_in;
         symbols_high_ff <= symbols_high_in;
      end
   end

   sirs_front #(
      .MAX_RADIX (MAX_RADIX)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_number (req_number),
      .radix      (radix_ff),
      .alphabet   (alphabet),
      .queue_full (queue_full),
      .push       (push),
      .push_word  (push_word)
   );

   sirs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_word  (q_word)
   );

   sirs_back #(
      .MAX_RADIX (MAX_RADIX)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_word       (q_word),
      .q_pop        (q_pop),
      .radix        (radix_ff),
      .alphabet     (alphabet),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_symbol   (rsp_symbol),
      .rsp_last     (rsp_last),
      .rsp_bad_base (rsp_bad_base)
   );

endmodule

[rtl/sirs_checker.sv]
// Port checker for the radix symbol renderer and its bind to the top level.
`include "signed_integer_to_radix_symbols_macros.svh"

module sirs_checker import sirs_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SYMBOL_BITS-1:0] rsp_symbol,
   input logic                   rsp_last,
   input logic                   rsp_bad_base
);

   `SIRS_ASSERT_NOW(error_word_shape, clock, reset, rsp_valid && rsp_bad_base, rsp_last && (rsp_symbol == 8'h00), "error word must be last with a zero symbol")

   `SIRS_ASSERT_NOW(sign_not_last, clock, reset, rsp_valid && (rsp_symbol == MINUS_CHAR), !rsp_last && !rsp_bad_base, "minus sign must be followed by digits")

   `SIRS_ASSERT_NEXT(reset_clears_output, clock, 1'b0, reset, !rsp_valid, "output word present after reset")

   `SIRS_ASSERT_NEXT(stalled_word_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol) && $stable(rsp_last) && $stable(rsp_bad_base), "stalled output word changed")

endmodule

bind signed_integer_to_radix_symbols sirs_checker u_checker (.*);
